>>> rtl/dual_pid_time_proportioning_control_defines.svh
// Assertion macros used by the top-level design file.
`ifndef DUAL_PID_TIME_PROPORTIONING_CONTROL_DEFINES_SVH
`define DUAL_PID_TIME_PROPORTIONING_CONTROL_DEFINES_SVH
`ifndef SYNTHESIS
// Checked while out of reset
`define DPID_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("dpid check failed");
// Checked on every edge, reset included
`define DPID_ASSERT_RST(lbl, prop) \
    lbl: assert property (@(posedge i_clk) prop) \
        else $error("dpid reset check failed");
`else
`define DPID_ASSERT(lbl, prop)
`define DPID_ASSERT_RST(lbl, prop)
`endif
`endif

>>> rtl/dpid_pkg.sv
package dpid_pkg;

    localparam int HEAT_LOCKOUT   = 1;
    localparam int PWM_PERIOD     = 10;
    localparam int PHASE_STEP     = 10;
    localparam int COOL_SPLIT     = 50;
    localparam int INTEGRAL_LIMIT = 1000;
    localparam int OUTPUT_DIVISOR = 100;

    localparam int TEMP_W  = 10;
    localparam int GAIN_W  = 8;
    localparam int PHASE_W = 4;
    localparam int ERR_W   = 11;
    localparam int DER_W   = 12;
    localparam int LEVEL_W = 15;
    localparam int SUM_W   = 22;
    localparam int MAG_W   = 21;

    // floor(x/100) ~ (x * DIV_RECIP) >> DIV_SHIFT, low by at most one for x < 2**MAG_W
    localparam int DIV_SHIFT = 27;
    localparam int RECIP_W   = 21;
    localparam logic [RECIP_W-1:0] DIV_RECIP = RECIP_W'((64'd1 << DIV_SHIFT) / OUTPUT_DIVISOR);

    localparam int CFG_IDX_W = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_HEAT_TARGET = 3'd0,
        CFG_COOL_TARGET = 3'd1,
        CFG_HEAT_KP     = 3'd2,
        CFG_HEAT_KI     = 3'd3,
        CFG_HEAT_KD     = 3'd4,
        CFG_COOL_KP     = 3'd5,
        CFG_COOL_KI     = 3'd6,
        CFG_COOL_KD     = 3'd7
    } t_cfg_idx;

    // stage loads and wrap marks handed to each PID loop
    typedef struct packed {
        logic ld2;
        logic ld3;
        logic ld4;
        logic ld5;
        logic ld6;
        logic wrap1;
        logic wrap5;
    } t_loop_ctl;

endpackage

>>> rtl/dpid_loop.sv
module dpid_loop import dpid_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  t_loop_ctl                 i_ctl,
    input  logic signed [ERR_W-1:0]   i_error,
    input  logic [GAIN_W-1:0]         i_kp,
    input  logic [GAIN_W-1:0]         i_ki,
    input  logic [GAIN_W-1:0]         i_kd,
    output logic signed [LEVEL_W-1:0] o_drive
);

    localparam logic signed [ERR_W:0] LIM_HI = (ERR_W+1)'(INTEGRAL_LIMIT);
    localparam logic signed [ERR_W:0] LIM_LO = (ERR_W+1)'(-INTEGRAL_LIMIT);

    logic signed [ERR_W-1:0]   r_integral;
    logic signed [ERR_W-1:0]   r_last_err;
    logic signed [LEVEL_W-1:0] r_drive;

    logic signed [ERR_W-1:0]   r_err2;
    logic signed [ERR_W-1:0]   r_acc2;
    logic signed [DER_W-1:0]   r_der2;
    logic signed [ERR_W+GAIN_W:0] r_pkp;
    logic signed [ERR_W+GAIN_W:0] r_pki;
    logic signed [DER_W+GAIN_W:0] r_pkd;
    logic [MAG_W-1:0]          r_mag4;
    logic                      r_neg4;
    logic [MAG_W-1:0]          r_mag5;
    logic                      r_neg5;
    logic [LEVEL_W-1:0]        r_q5;

    logic signed [ERR_W:0]     n_acc_full;
    logic signed [ERR_W-1:0]   n_acc;
    logic signed [DER_W-1:0]   n_der;
    logic signed [ERR_W+GAIN_W:0] n_pkp;
    logic signed [ERR_W+GAIN_W:0] n_pki;
    logic signed [DER_W+GAIN_W:0] n_pkd;
    logic signed [SUM_W-1:0]   n_sum;
    logic [SUM_W-1:0]          n_abs;
    logic [MAG_W+RECIP_W-1:0]  n_prod;
    logic [SUM_W-1:0]          n_qx100;
    logic [SUM_W-1:0]          n_rem;
    logic [LEVEL_W-1:0]        n_qc;
    logic signed [LEVEL_W-1:0] n_drive;

    // error, clamped integral and difference
    always_comb begin
        n_acc_full = {r_integral[ERR_W-1], r_integral} + {i_error[ERR_W-1], i_error};
        if (n_acc_full > LIM_HI) begin
            n_acc = LIM_HI[ERR_W-1:0];
        end else if (n_acc_full < LIM_LO) begin
            n_acc = LIM_LO[ERR_W-1:0];
        end else begin
            n_acc = n_acc_full[ERR_W-1:0];
        end
        n_der = {i_error[ERR_W-1], i_error} - {r_last_err[ERR_W-1], r_last_err};
    end

    assign n_pkp = $signed({1'b0, i_kp}) * r_err2;
    assign n_pki = $signed({1'b0, i_ki}) * r_acc2;
    assign n_pkd = $signed({1'b0, i_kd}) * r_der2;

    assign n_sum  = SUM_W'(r_pkp) + SUM_W'(r_pki) + SUM_W'(r_pkd);
    assign n_abs  = n_sum[SUM_W-1] ? SUM_W'(-n_sum) : SUM_W'(n_sum);
    assign n_prod = (MAG_W+RECIP_W)'(r_mag4) * (MAG_W+RECIP_W)'(DIV_RECIP);

    // reciprocal estimate may sit one low: fix with the remainder
    assign n_qx100 = SUM_W'(r_q5) * SUM_W'(OUTPUT_DIVISOR);
    assign n_rem   = SUM_W'(r_mag5) - n_qx100;
    assign n_qc    = (n_rem >= SUM_W'(OUTPUT_DIVISOR)) ? r_q5 + 1'b1 : r_q5;
    assign n_drive = r_neg5 ? LEVEL_W'(-$signed(n_qc)) : $signed(n_qc);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_integral <= '0;
            r_last_err <= '0;
            r_drive    <= '0;
        end else begin
            if (i_ctl.ld2 && i_ctl.wrap1) begin
                r_integral <= n_acc;
                r_last_err <= i_error;
            end
            if (i_ctl.ld6 && i_ctl.wrap5) begin
                r_drive <= n_drive;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.ld2) begin
            r_err2 <= i_error;
            r_acc2 <= n_acc;
            r_der2 <= n_der;
        end
        if (i_ctl.ld3) begin
            r_pkp <= n_pkp;
            r_pki <= n_pki;
            r_pkd <= n_pkd;
        end
        if (i_ctl.ld4) begin
            r_mag4 <= n_abs[MAG_W-1:0];
            r_neg4 <= n_sum[SUM_W-1];
        end
        if (i_ctl.ld5) begin
            r_q5   <= n_prod[DIV_SHIFT +: LEVEL_W];
            r_mag5 <= r_mag4;
            r_neg5 <= r_neg4;
        end
    end

    assign o_drive = r_drive;

endmodule

>>> rtl/dpid_relay.sv
module dpid_relay import dpid_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_ld,
    input  logic [PHASE_W-1:0]        i_phase,
    input  logic signed [LEVEL_W-1:0] i_heat_drive,
    input  logic signed [LEVEL_W-1:0] i_cool_drive,
    output logic                      o_heat_on,
    output logic                      o_cool_on,
    output logic                      o_fan_on,
    output logic signed [LEVEL_W-1:0] o_heat_level,
    output logic signed [LEVEL_W-1:0] o_cool_level
);

    localparam int CMP_W = LEVEL_W + 2;
    localparam logic signed [CMP_W-1:0] SPLIT_S = CMP_W'(COOL_SPLIT);

    logic                      r_heat;
    logic                      r_cool;
    logic                      r_fan;
    logic signed [LEVEL_W-1:0] r_heat_lvl;
    logic signed [LEVEL_W-1:0] r_cool_lvl;

    logic [7:0]              n_slot;
    logic signed [CMP_W-1:0] n_slot_s;
    logic signed [CMP_W-1:0] n_hd;
    logic signed [CMP_W-1:0] n_cd;
    logic signed [CMP_W-1:0] n_cool_dbl;
    logic signed [CMP_W-1:0] n_fan_dbl;
    logic                    n_low_band;
    logic                    n_high_band;
    logic                    n_cool;
    logic                    n_fan;
    logic                    n_heat;

    always_comb begin
        n_slot      = 8'(i_phase * PHASE_STEP);
        n_slot_s    = $signed({{(CMP_W-8){1'b0}}, n_slot});
        n_hd        = {{2{i_heat_drive[LEVEL_W-1]}}, i_heat_drive};
        n_cd        = {{2{i_cool_drive[LEVEL_W-1]}}, i_cool_drive};
        n_cool_dbl  = n_cd <<< 1;
        n_fan_dbl   = (n_cd - SPLIT_S) <<< 1;
        n_low_band  = (n_cd > 0) && (n_cd <= SPLIT_S);
        n_high_band = n_cd > SPLIT_S;
        // low band proportions the cooler; above it the cooler holds and the fan proportions
        n_cool      = n_low_band ? (n_cool_dbl > n_slot_s) : n_high_band;
        n_fan       = n_high_band && (n_fan_dbl > n_slot_s);
        if ((HEAT_LOCKOUT != 0) && (n_cool || n_fan)) begin
            n_heat = 1'b0;
        end else begin
            n_heat = n_hd > n_slot_s;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ld) begin
            r_heat     <= n_heat;
            r_cool     <= n_cool;
            r_fan      <= n_fan;
            r_heat_lvl <= i_heat_drive;
            r_cool_lvl <= i_cool_drive;
        end
    end

    assign o_heat_on    = r_heat;
    assign o_cool_on    = r_cool;
    assign o_fan_on     = r_fan;
    assign o_heat_level = r_heat_lvl;
    assign o_cool_level = r_cool_lvl;

endmodule

>>> rtl/dual_pid_time_proportioning_control.sv
// Dual PID thermostat with time-proportioned heater, cooler and fan relays.
// Input stream: one request per one-second tick, s_axis_tdata[9:0] = temperature.
// Output stream: one result per request, in order:
//   m_axis_tdata[0] heat_on, [1] cool_on, [2] fan_on,
//   [17:3] heat_level, [32:18] cool_level (both signed), rest zero.
// Setpoints and gains go in over the i_cfg_* write port (index 0..7) while idle.
// Every tenth tick both loops update; the other ticks only sweep the relay slot.
// Throughput: one request per cycle unless m_axis_tready stalls the output. The path runs
// through an input register, five stages (error, gain multiply, sum, reciprocal
// multiply, divide correction) and the relay decision output register.
// Each stage holds its request only while the next one is full, so a stalled
// m_axis_tready fills the empty stages first and s_axis_tready drops once all are full.
// Synchronous active-low reset clears the pipe, the phase counter, both loop
// integrals, last errors and drives, and restores the register defaults.
`include "dual_pid_time_proportioning_control_defines.svh"
module dual_pid_time_proportioning_control import dpid_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [15:0]          s_axis_tdata,   // [9:0] temperature
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [39:0]          m_axis_tdata,   // heat_on, cool_on, fan_on, heat_level, cool_level
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [GAIN_W-1:0]    i_cfg_data
);

    localparam int NSTG = 6;

    logic [GAIN_W-1:0] r_heat_target, r_cool_target;
    logic [GAIN_W-1:0] r_heat_kp, r_heat_ki, r_heat_kd;
    logic [GAIN_W-1:0] r_cool_kp, r_cool_ki, r_cool_kd;

    logic [PHASE_W-1:0]  r_phase;
    logic [NSTG:1]       r_vld;
    logic                r_out_valid;
    logic [PHASE_W-1:0]  r_ph [1:NSTG];
    logic [NSTG-1:1]     r_wrap;
    logic [TEMP_W-1:0]   r_temp1;

    logic [NSTG+1:1]     rdy;
    logic [NSTG+1:1]     ld;
    logic [PHASE_W-1:0]  n_phase;
    logic                n_wrap;
    logic signed [ERR_W-1:0] n_heat_err;
    logic signed [ERR_W-1:0] n_cool_err;
    t_loop_ctl           loop_ctl;

    logic signed [LEVEL_W-1:0] heat_drive, cool_drive;
    logic signed [LEVEL_W-1:0] heat_lvl, cool_lvl;
    logic                      heat, cool, fan;

    // ready ripples back: a stage takes a request when empty or emptying
    always_comb begin
        rdy[NSTG+1] = !r_out_valid || m_axis_tready;
        ld[NSTG+1]  = r_vld[NSTG] && rdy[NSTG+1];
        for (int k = NSTG; k >= 2; k--) begin
            rdy[k]  = !r_vld[k] || rdy[k+1];
            ld[k]   = r_vld[k-1] && rdy[k];
        end
        rdy[1] = !r_vld[1] || rdy[2];
        ld[1]  = s_axis_tvalid && rdy[1];
    end

    assign s_axis_tready = rdy[1];

    assign n_wrap  = r_phase == PHASE_W'(PWM_PERIOD - 1);
    assign n_phase = n_wrap ? '0 : r_phase + 1'b1;

    assign n_heat_err = $signed({3'b000, r_heat_target}) - $signed({1'b0, r_temp1});
    assign n_cool_err = $signed({1'b0, r_temp1}) - $signed({3'b000, r_cool_target});

    assign loop_ctl = '{ld2: ld[2], ld3: ld[3], ld4: ld[4], ld5: ld[5], ld6: ld[6],
                        wrap1: r_wrap[1], wrap5: r_wrap[5]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_heat_target <= 8'd20;
            r_cool_target <= 8'd28;
            r_heat_kp     <= 8'd100;
            r_heat_ki     <= 8'd10;
            r_heat_kd     <= 8'd5;
            r_cool_kp     <= 8'd100;
            r_cool_ki     <= 8'd10;
            r_cool_kd     <= 8'd5;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_HEAT_TARGET: r_heat_target <= i_cfg_data;
                CFG_COOL_TARGET: r_cool_target <= i_cfg_data;
                CFG_HEAT_KP:     r_heat_kp     <= i_cfg_data;
                CFG_HEAT_KI:     r_heat_ki     <= i_cfg_data;
                CFG_HEAT_KD:     r_heat_kd     <= i_cfg_data;
                CFG_COOL_KP:     r_cool_kp     <= i_cfg_data;
                CFG_COOL_KI:     r_cool_ki     <= i_cfg_data;
                CFG_COOL_KD:     r_cool_kd     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= '0;
            r_vld       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (ld[1]) begin
                r_phase <= n_phase;
            end
            if (rdy[1]) begin
                r_vld[1] <= s_axis_tvalid;
            end
            for (int k = 2; k <= NSTG; k++) begin
                if (rdy[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
            if (rdy[NSTG+1]) begin
                r_out_valid <= r_vld[NSTG];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (ld[1]) begin
            r_temp1   <= s_axis_tdata[TEMP_W-1:0];
            r_ph[1]   <= n_phase;
            r_wrap[1] <= n_wrap;
        end
        for (int k = 2; k <= NSTG; k++) begin
            if (ld[k]) begin
                r_ph[k] <= r_ph[k-1];
            end
        end
        for (int k = 2; k <= NSTG - 1; k++) begin
            if (ld[k]) begin
                r_wrap[k] <= r_wrap[k-1];
            end
        end
    end

    dpid_loop u_heat_loop (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (loop_ctl),
        .i_error (n_heat_err),
        .i_kp    (r_heat_kp),
        .i_ki    (r_heat_ki),
        .i_kd    (r_heat_kd),
        .o_drive (heat_drive)
    );

    dpid_loop u_cool_loop (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (loop_ctl),
        .i_error (n_cool_err),
        .i_kp    (r_cool_kp),
        .i_ki    (r_cool_ki),
        .i_kd    (r_cool_kd),
        .o_drive (cool_drive)
    );

    dpid_relay u_relay (
        .i_clk        (i_clk),
        .i_ld         (ld[NSTG+1]),
        .i_phase      (r_ph[NSTG]),
        .i_heat_drive (heat_drive),
        .i_cool_drive (cool_drive),
        .o_heat_on    (heat),
        .o_cool_on    (cool),
        .o_fan_on     (fan),
        .o_heat_level (heat_lvl),
        .o_cool_level (cool_lvl)
    );

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {7'b0, cool_lvl, heat_lvl, fan, cool, heat};

    `DPID_ASSERT(a_phase_range, r_phase <= PHASE_W'(PWM_PERIOD - 1))
    `DPID_ASSERT(a_wrap_at_zero, r_vld[1] && r_wrap[1] |-> r_ph[1] == '0)
    `DPID_ASSERT(a_phase_idle, !(s_axis_tvalid && s_axis_tready) |=> $stable(r_phase))
    `DPID_ASSERT(a_heat_lockout, m_axis_tvalid && (cool || fan) |-> !heat)
    `DPID_ASSERT(a_fan_needs_cool, m_axis_tvalid && fan |-> cool)
    `DPID_ASSERT_RST(a_reset_empty, !i_rst_n |=> !m_axis_tvalid && r_vld == '0)

endmodule

>>> sim/dual_pid_time_proportioning_control_test.sv
`timescale 1ns / 100ps

module dual_pid_time_proportioning_control_test import dpid_pkg::*;;

    localparam int CLK_HALF      = 6;
    localparam int RESET_CYCLES  = 5;
    localparam int SETTLE_CYCLES = 12;
    localparam int HOLD_CYCLES   = 60;
    localparam int PHASE_TICKS   = 105;
    localparam int PHASES        = 6;
    localparam int DIRECT_ROWS   = 25;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int PRINT_LIMIT   = 50;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [15:0]          s_axis_tdata;   // [9:0] temperature
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    logic [39:0]          m_axis_tdata;   // heat_on, cool_on, fan_on, heat_level, cool_level
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [GAIN_W-1:0]    i_cfg_data;

    dual_pid_time_proportioning_control i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    typedef struct packed {
        bit          typed;
        logic [9:0]  temp;
        logic [39:0] want;
    } t_tick_row;

    // First nine ticks after reset hold both drives at zero, so every relay is off
    t_tick_row tick_rows [DIRECT_ROWS] = '{
        '{1'b1, 10'd0,    40'd0},
        '{1'b1, 10'd1023, 40'd0},
        '{1'b1, 10'd512,  40'd0},
        '{1'b1, 10'd341,  40'd0},
        '{1'b1, 10'd682,  40'd0},
        '{1'b1, 10'd1,    40'd0},
        '{1'b1, 10'd1022, 40'd0},
        '{1'b1, 10'd28,   40'd0},
        '{1'b1, 10'd20,   40'd0},
        '{1'b0, 10'd1023, 40'd0},   // update: heat integral clamps, fan proportioned
        '{1'b0, 10'd20,   40'd0},
        '{1'b0, 10'd21,   40'd0},
        '{1'b0, 10'd19,   40'd0},
        '{1'b0, 10'd29,   40'd0},
        '{1'b0, 10'd27,   40'd0},
        '{1'b0, 10'd28,   40'd0},
        '{1'b0, 10'd255,  40'd0},
        '{1'b0, 10'd256,  40'd0},
        '{1'b0, 10'd0,    40'd0},
        '{1'b0, 10'd0,    40'd0},   // update: negative heat sum truncates toward zero
        '{1'b0, 10'd20,   40'd0},
        '{1'b0, 10'd20,   40'd0},
        '{1'b0, 10'd20,   40'd0},
        '{1'b0, 10'd20,   40'd0},
        '{1'b0, 10'd20,   40'd0}
    };

    // predictor state
    logic [7:0] cfg_copy [8];
    logic [7:0] cfg_next [8];
    int         tick_phase;
    int         heat_integ, heat_prev, heat_drive;
    int         cool_integ, cool_prev, cool_drive;

    logic [39:0] relay_due [$];
    int          fault_count;
    int          cycle_count;
    int          src_idle_pct;
    int          sink_stall_pct;
    logic        sink_hold;

    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        if (fault_count < PRINT_LIMIT)
            $display("%0t relay %s: got %0d, want %0d", $time, what, got, want);
        fault_count++;
    endtask

    function automatic int loop_output(inout int integ, inout int prev_err, input int err,
                                       input int kp, input int ki, input int kd);
        int sum;
        integ = integ + err;
        if (integ > INTEGRAL_LIMIT) integ = INTEGRAL_LIMIT;
        if (integ < -INTEGRAL_LIMIT) integ = -INTEGRAL_LIMIT;
        sum = kp * err + ki * integ + kd * (err - prev_err);
        prev_err = err;
        return sum / OUTPUT_DIVISOR;
    endfunction

    function automatic logic [39:0] predict_relays(input logic [9:0] t);
        int temp;
        int slot;
        bit heat = 1'b0;
        bit cool = 1'b0;
        bit fan  = 1'b0;
        temp = t;
        tick_phase = tick_phase + 1;
        if (tick_phase >= PWM_PERIOD) begin
            tick_phase = 0;
            heat_drive = loop_output(heat_integ, heat_prev,
                                     int'(cfg_copy[CFG_HEAT_TARGET]) - temp,
                                     cfg_copy[CFG_HEAT_KP], cfg_copy[CFG_HEAT_KI],
                                     cfg_copy[CFG_HEAT_KD]);
            cool_drive = loop_output(cool_integ, cool_prev,
                                     temp - int'(cfg_copy[CFG_COOL_TARGET]),
                                     cfg_copy[CFG_COOL_KP], cfg_copy[CFG_COOL_KI],
                                     cfg_copy[CFG_COOL_KD]);
        end
        slot = tick_phase * PHASE_STEP;
        if (cool_drive > 0 && cool_drive <= COOL_SPLIT) begin
            cool = (cool_drive * 2) > slot;
        end else if (cool_drive > COOL_SPLIT) begin
            cool = 1'b1;
            fan  = ((cool_drive - COOL_SPLIT) * 2) > slot;
        end
        heat = (HEAT_LOCKOUT != 0 && (cool || fan)) ? 1'b0 : (heat_drive > slot);
        return {7'd0, 15'(cool_drive), 15'(heat_drive), fan, cool, heat};
    endfunction

    task automatic check_relays(input logic [39:0] got);
        logic [39:0] want;
        if (relay_due.size() == 0) begin
            report_mismatch("result with none pending", int'(got[32:0]), 0);
            return;
        end
        want = relay_due.pop_front();
        if (got[0] !== want[0]) report_mismatch("heat_on", got[0], want[0]);
        if (got[1] !== want[1]) report_mismatch("cool_on", got[1], want[1]);
        if (got[2] !== want[2]) report_mismatch("fan_on", got[2], want[2]);
        if (got[17:3] !== want[17:3])
            report_mismatch("heat_level", $signed(got[17:3]), $signed(want[17:3]));
        if (got[32:18] !== want[32:18])
            report_mismatch("cool_level", $signed(got[32:18]), $signed(want[32:18]));
        if (got[39:33] !== want[39:33]) report_mismatch("padding", got[39:33], want[39:33]);
    endtask

    // sink side: check at the edge, then decide tready for the next cycle
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            check_relays(m_axis_tdata);
        m_axis_tready <= !sink_hold && ($urandom_range(99) >= sink_stall_pct);
    end

    task automatic offer_tick(input logic [9:0] t, input bit typed, input logic [39:0] want);
        logic [39:0] predicted;
        while ($urandom_range(99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {6'd0, t};
        do @(posedge i_clk); while (!s_axis_tready);
        predicted = predict_relays(t);
        relay_due.push_back(typed ? want : predicted);
    endtask

    task automatic wait_drained();
        while (relay_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic load_config();
        for (int k = 0; k < 8; k++) begin
            i_cfg_we    <= 1'b1;
            i_cfg_index <= t_cfg_idx'(k);
            i_cfg_data  <= cfg_next[k];
            @(posedge i_clk);
            cfg_copy[k] = cfg_next[k];
        end
        i_cfg_we <= 1'b0;
    endtask

    // mostly near a setpoint so the loops sit in their interesting range
    function automatic logic [9:0] pick_temperature();
        int roll;
        int base;
        roll = $urandom_range(99);
        if (roll < 10) return 10'($urandom);
        if (roll < 12) return 10'd0;
        if (roll < 14) return 10'd1023;
        base = (roll < 57) ? int'(cfg_copy[CFG_HEAT_TARGET]) : int'(cfg_copy[CFG_COOL_TARGET]);
        base = base + int'($urandom_range(30)) - 15;
        if (base < 0) base = 0;
        return 10'(base);
    endfunction

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("dual_pid_time_proportioning_control: mismatch");
        $finish;
    end

    initial begin
        i_rst_n        = 1'b0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = '0;
        i_cfg_we       = 1'b0;
        i_cfg_index    = CFG_HEAT_TARGET;
        i_cfg_data     = '0;
        sink_hold      = 1'b0;
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        fault_count    = 0;
        cfg_copy[CFG_HEAT_TARGET] = 8'd20;
        cfg_copy[CFG_COOL_TARGET] = 8'd28;
        cfg_copy[CFG_HEAT_KP]     = 8'd100;
        cfg_copy[CFG_HEAT_KI]     = 8'd10;
        cfg_copy[CFG_HEAT_KD]     = 8'd5;
        cfg_copy[CFG_COOL_KP]     = 8'd100;
        cfg_copy[CFG_COOL_KI]     = 8'd10;
        cfg_copy[CFG_COOL_KD]     = 8'd5;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int r = 0; r < DIRECT_ROWS; r++)
            offer_tick(tick_rows[r].temp, tick_rows[r].typed, tick_rows[r].want);
        s_axis_tvalid <= 1'b0;
        wait_drained();

        for (int ph = 0; ph < PHASES; ph++) begin
            for (int k = 0; k < 8; k++)
                cfg_next[k] = (ph == 0) ? 8'hFF : (ph == 1) ? 8'h00 : 8'($urandom);
            if (ph == 2) begin
                // small proportional and integral gains aim to keep the drives inside the proportioned bands
                cfg_next[CFG_HEAT_KP] = 8'($urandom_range(20));
                cfg_next[CFG_HEAT_KI] = 8'($urandom_range(5));
                cfg_next[CFG_COOL_KP] = 8'($urandom_range(20));
                cfg_next[CFG_COOL_KI] = 8'($urandom_range(5));
            end
            if (ph == 3) begin
                // heating setpoint above cooling one: heater lockout gets exercised
                cfg_next[CFG_HEAT_TARGET] = 8'd200;
                cfg_next[CFG_COOL_TARGET] = 8'd60;
            end
            load_config();

            src_idle_pct   = (ph % 4 == 1) ? 79 : (ph % 4 == 3) ? 29 : 0;
            sink_stall_pct = (ph % 4 == 2) ? 79 : (ph % 4 == 3) ? 29 : 0;

            if (ph == 0) begin
                // sink holds off while requests keep coming, filling the pipe
                fork
                    begin
                        sink_hold <= 1'b1;
                        repeat (HOLD_CYCLES) @(posedge i_clk);
                        sink_hold <= 1'b0;
                    end
                join_none
            end

            for (int n = 0; n < PHASE_TICKS; n++) begin
                if (ph == 3 && n == PHASE_TICKS / 2) begin
                    s_axis_tvalid <= 1'b0;
                    wait_drained();
                end
                offer_tick(pick_temperature(), 1'b0, '0);
            end
            s_axis_tvalid <= 1'b0;
            wait_drained();
        end

        if (fault_count == 0)
            $display("dual_pid_time_proportioning_control: match");
        else
            $display("dual_pid_time_proportioning_control: mismatch");
        $finish;
    end

endmodule
